// ===== design/zmv_pkg.sv =====
// zmv_pkg: shared widths, opcode, fetch mode and register codes for the variable unit
package zmv_pkg;

    localparam int DATA_W       = 16;
    localparam int FP_CFG_W     = 11;
    localparam int FIRST_GLOBAL = 16;
    localparam int GLOBAL_COUNT = 256 - FIRST_GLOBAL;
    localparam int GLB_AW       = $clog2(GLOBAL_COUNT);
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = PADDR_W - 2;

    typedef logic [3:0]               t_opcode;
    typedef logic [7:0]               t_var;
    typedef logic [DATA_W-1:0]        t_data;
    typedef logic signed [DATA_W-1:0] t_threshold;
    typedef logic [1:0]               t_mode;

    localparam t_opcode OP_LOAD    = 4'd0;
    localparam t_opcode OP_STORE   = 4'd1;
    localparam t_opcode OP_PUSH    = 4'd2;
    localparam t_opcode OP_POP     = 4'd3;
    localparam t_opcode OP_INC     = 4'd4;
    localparam t_opcode OP_DEC     = 4'd5;
    localparam t_opcode OP_INC_CHK = 4'd6;
    localparam t_opcode OP_DEC_CHK = 4'd7;
    localparam t_opcode OP_FETCH   = 4'd8;

    localparam t_mode MODE_WORD = 2'd0;
    localparam t_mode MODE_BYTE = 2'd1;

    localparam logic [REG_IDX_W-1:0] REG_FP = '0;

endpackage

// ===== design/zmv_in_if.sv =====
// zmv_in_if: request channel carrying one variable operation
interface zmv_in_if;
    logic                  valid;
    logic                  ready;
    zmv_pkg::t_opcode      opcode;
    zmv_pkg::t_var         var_number;
    zmv_pkg::t_data        data_value;
    zmv_pkg::t_threshold   threshold;
    zmv_pkg::t_mode        fetch_mode;

    modport source (
        output valid, opcode, var_number, data_value, threshold, fetch_mode,
        input  ready
    );
    modport sink (
        input  valid, opcode, var_number, data_value, threshold, fetch_mode,
        output ready
    );
endinterface

// ===== design/zmv_out_if.sv =====
// zmv_out_if: result channel carrying value, check flag and stack error
interface zmv_out_if;
    logic           valid;
    logic           ready;
    zmv_pkg::t_data read_value;
    logic           condition;
    logic           stack_error;

    modport source (
        output valid, read_value, condition, stack_error,
        input  ready
    );
    modport sink (
        input  valid, read_value, condition, stack_error,
        output ready
    );
endinterface

// ===== design/zmachine_variable_unit.sv =====
// zmachine_variable_unit: z-machine variable file over stack and global memories
// the result register loads in the execute state after the request transfer
// one request at a time: memories read at the transfer, written in execute
// a result not yet taken holds the execute state until the output register frees
// reset: stack empty (top at STACK_DEPTH), frame pointer at STACK_DEPTH, no result
// memory contents are not cleared and are defined only once written
module zmachine_variable_unit #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    zmv_in_if.sink                            i_item,
    zmv_out_if.source                         o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [zmv_pkg::PADDR_W-1:0]       paddr,
    input  logic [zmv_pkg::PDATA_W-1:0]       pwdata,
    output logic [zmv_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int TOP_W = $clog2(STACK_DEPTH + 1);
    localparam int FP_W  = (TOP_W > zmv_pkg::FP_CFG_W) ? TOP_W : zmv_pkg::FP_CFG_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // memories
    zmv_pkg::t_data stack_mem [STACK_DEPTH];
    zmv_pkg::t_data glb_mem   [zmv_pkg::GLOBAL_COUNT];

    t_state                r_state;
    logic [TOP_W-1:0]      r_stack_top;
    logic [FP_W-1:0]       r_fp;
    zmv_pkg::t_opcode      r_op;
    zmv_pkg::t_var         r_var;
    zmv_pkg::t_data        r_data;
    zmv_pkg::t_threshold   r_th;
    zmv_pkg::t_mode        r_mode;
    zmv_pkg::t_data        r_stack_rd;
    zmv_pkg::t_data        r_glb_rd;
    logic                  r_out_valid;
    zmv_pkg::t_data        r_out_value;
    logic                  r_out_cond;
    logic                  r_out_err;

    logic                  accept;
    logic                  out_free;
    logic                  exec_fire;
    logic                  cfg_write;

    // read side, at the request transfer
    logic                  in_local;
    logic [FP_W:0]         in_diff;
    logic                  in_loc_ok;
    logic                  st_re;
    logic [AW-1:0]         st_ra;
    logic                  gl_re;
    logic [zmv_pkg::GLB_AW-1:0] gl_ra;

    // execute side
    logic                  is_top;
    logic                  is_loc;
    logic                  empty;
    logic [FP_W:0]         ex_diff;
    logic                  ex_loc_ok;
    logic [TOP_W-1:0]      top_inc;
    logic [TOP_W-1:0]      top_dec;
    zmv_pkg::t_data        cur;
    zmv_pkg::t_data        n_rv;
    logic                  n_cond;
    logic                  n_err;
    logic [TOP_W-1:0]      n_stack_top;
    logic                  vw_en;
    zmv_pkg::t_data        vw_val;
    logic [AW-1:0]         vw_top_addr;
    logic                  st_we;
    logic [AW-1:0]         st_wa;
    zmv_pkg::t_data        st_wd;
    logic                  gl_we;
    logic [zmv_pkg::GLB_AW-1:0] gl_wa;
    t_state                n_state;

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign out_free     = !r_out_valid || o_result.ready;
    assign exec_fire    = (r_state == S_EXEC) && out_free;

    assign o_result.valid       = r_out_valid;
    assign o_result.read_value  = r_out_value;
    assign o_result.condition   = r_out_cond;
    assign o_result.stack_error = r_out_err;

    // apb register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[zmv_pkg::PADDR_W-1:2] == zmv_pkg::REG_FP);
    assign prdata    = (paddr[zmv_pkg::PADDR_W-1:2] == zmv_pkg::REG_FP)
                       ? zmv_pkg::PDATA_W'(r_fp) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp <= FP_W'(STACK_DEPTH);
        end else if (cfg_write) begin
            r_fp <= FP_W'(pwdata[zmv_pkg::FP_CFG_W-1:0]);
        end
    end

    // read address decode
    always_comb begin
        in_local  = (i_item.var_number != '0)
                    && (i_item.var_number < 8'(zmv_pkg::FIRST_GLOBAL));
        in_diff   = {1'b0, r_fp} - (FP_W+1)'(i_item.var_number);
        in_loc_ok = !in_diff[FP_W] && (in_diff[FP_W-1:0] < FP_W'(STACK_DEPTH));
        if (in_local && (i_item.opcode != zmv_pkg::OP_POP)) begin
            st_re = accept && in_loc_ok;
            st_ra = in_diff[AW-1:0];
        end else begin
            st_re = accept && (r_stack_top != TOP_W'(STACK_DEPTH));
            st_ra = r_stack_top[AW-1:0];
        end
        gl_re = accept && !in_local && (i_item.var_number != '0);
        gl_ra = zmv_pkg::GLB_AW'(i_item.var_number - 8'(zmv_pkg::FIRST_GLOBAL));
    end

    always_ff @(posedge i_clk) begin
        if (st_re) begin
            r_stack_rd <= stack_mem[st_ra];
        end
        if (st_we) begin
            stack_mem[st_wa] <= st_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gl_re) begin
            r_glb_rd <= glb_mem[gl_ra];
        end
        if (gl_we) begin
            glb_mem[gl_wa] <= vw_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_item.opcode;
            r_var  <= i_item.var_number;
            r_data <= i_item.data_value;
            r_th   <= i_item.threshold;
            r_mode <= i_item.fetch_mode;
        end
    end

    // execute and write back
    always_comb begin
        is_top      = (r_var == '0);
        is_loc      = !is_top && (r_var < 8'(zmv_pkg::FIRST_GLOBAL));
        empty       = (r_stack_top == TOP_W'(STACK_DEPTH));
        ex_diff     = {1'b0, r_fp} - (FP_W+1)'(r_var);
        ex_loc_ok   = !ex_diff[FP_W] && (ex_diff[FP_W-1:0] < FP_W'(STACK_DEPTH));
        top_inc     = r_stack_top + TOP_W'(1);
        top_dec     = r_stack_top - TOP_W'(1);
        if (is_top) begin
            cur = r_stack_rd;
        end else if (is_loc) begin
            cur = ex_loc_ok ? r_stack_rd : '0;
        end else begin
            cur = r_glb_rd;
        end

        n_rv        = '0;
        n_cond      = 1'b0;
        n_err       = 1'b0;
        n_stack_top = r_stack_top;
        vw_en       = 1'b0;
        vw_val      = r_data;
        vw_top_addr = r_stack_top[AW-1:0];
        st_we       = 1'b0;
        st_wa       = r_stack_top[AW-1:0];
        st_wd       = r_data;

        case (r_op) inside
            zmv_pkg::OP_LOAD: begin
                n_err = is_top && empty;
                n_rv  = cur;
            end
            zmv_pkg::OP_STORE: begin
                n_err = is_top && empty;
                vw_en = !n_err;
            end
            zmv_pkg::OP_PUSH: begin
                if (r_stack_top == '0) begin
                    n_err = 1'b1;
                end else begin
                    n_stack_top = top_dec;
                    st_we       = 1'b1;
                    st_wa       = top_dec[AW-1:0];
                end
            end
            zmv_pkg::OP_POP: begin
                if (empty || (is_top && (r_stack_top >= TOP_W'(STACK_DEPTH - 1)))) begin
                    n_err = 1'b1;
                end else begin
                    n_rv        = r_stack_rd;
                    n_stack_top = top_inc;
                    vw_en       = 1'b1;
                    vw_val      = r_stack_rd;
                    vw_top_addr = top_inc[AW-1:0];
                end
            end
            zmv_pkg::OP_INC, zmv_pkg::OP_DEC, zmv_pkg::OP_INC_CHK, zmv_pkg::OP_DEC_CHK: begin
                n_err = is_top && empty;
                if ((r_op == zmv_pkg::OP_INC) || (r_op == zmv_pkg::OP_INC_CHK)) begin
                    n_rv = cur + zmv_pkg::DATA_W'(1);
                end else begin
                    n_rv = cur - zmv_pkg::DATA_W'(1);
                end
                vw_en  = !n_err;
                vw_val = n_rv;
                if (r_op == zmv_pkg::OP_INC_CHK) begin
                    n_cond = $signed(n_rv) > r_th;
                end else if (r_op == zmv_pkg::OP_DEC_CHK) begin
                    n_cond = $signed(n_rv) < r_th;
                end
            end
            zmv_pkg::OP_FETCH: begin
                if (r_mode == zmv_pkg::MODE_WORD) begin
                    n_rv = r_data;
                end else if (r_mode == zmv_pkg::MODE_BYTE) begin
                    n_rv = {8'h00, r_data[7:0]};
                end else if (is_top) begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        n_rv        = r_stack_rd;
                        n_stack_top = top_inc;
                    end
                end else begin
                    n_rv = cur;
                end
            end
            default: begin
            end
        endcase

        if (n_err) begin
            n_rv   = '0;
            n_cond = 1'b0;
        end

        // variable write back
        if (vw_en && !is_top && !is_loc) begin
            gl_we = exec_fire;
        end else begin
            gl_we = 1'b0;
        end
        gl_wa = zmv_pkg::GLB_AW'(r_var - 8'(zmv_pkg::FIRST_GLOBAL));
        if (vw_en && is_top) begin
            st_we = 1'b1;
            st_wa = vw_top_addr;
            st_wd = vw_val;
        end else if (vw_en && is_loc) begin
            st_we = ex_loc_ok;
            st_wa = ex_diff[AW-1:0];
            st_wd = vw_val;
        end
        st_we = st_we && exec_fire;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stack_top <= TOP_W'(STACK_DEPTH);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_fire) begin
                r_stack_top <= n_stack_top;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out_value <= n_rv;
            r_out_cond  <= n_cond;
            r_out_err   <= n_err;
        end
    end

    // checks
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stack_top <= TOP_W'(STACK_DEPTH))
        else $error("stack top beyond stack depth");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("transfer not followed by execute cycle");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result appeared without execute cycle");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> (r_out_value == '0) && !r_out_cond)
        else $error("error result carries data");

    a_top_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_stack_top != $past(r_stack_top))
            |-> $past(exec_fire))
        else $error("stack top moved outside execute");

endmodule

// ===== sim/zmachine_variable_unit_tb.sv =====
// zmachine_variable_unit_tb: self-checking testbench for the variable unit, predictor against result stream
module zmachine_variable_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 1024;
    localparam int LIVE = 0;
    localparam int PLAN = 1;

    localparam zmv_pkg::t_opcode OP_SPARE_LO  = 4'd9;
    localparam zmv_pkg::t_opcode OP_SPARE_HI  = 4'd15;
    localparam zmv_pkg::t_mode   MODE_VAR     = 2'd2;
    localparam zmv_pkg::t_mode   MODE_VAR_ALT = 2'd3;
    localparam zmv_pkg::t_var    GLOBAL_LO    = 8'(zmv_pkg::FIRST_GLOBAL);

    typedef struct packed {
        zmv_pkg::t_opcode    opcode;
        zmv_pkg::t_var       var_number;
        zmv_pkg::t_data      data_value;
        zmv_pkg::t_threshold threshold;
        zmv_pkg::t_mode      fetch_mode;
    } t_var_op;

    typedef struct packed {
        zmv_pkg::t_data read_value;
        logic           condition;
        logic           stack_error;
    } t_var_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [zmv_pkg::PADDR_W-1:0]   paddr;
    logic [zmv_pkg::PDATA_W-1:0]   pwdata;
    logic [zmv_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;

    zmv_in_if  op_if();
    zmv_out_if res_if();

    zmachine_variable_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (op_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // two copies of the variable file: one follows accepted transfers, one plans stimulus
    zmv_pkg::t_data stack_mem [2][STACK_DEPTH];
    bit             stack_set [2][STACK_DEPTH];
    zmv_pkg::t_data glob_mem  [2][zmv_pkg::GLOBAL_COUNT];
    bit             glob_set  [2][zmv_pkg::GLOBAL_COUNT];
    int             stack_ptr [2];
    int             frame_ptr [2];

    t_var_op     pending_ops[$];
    t_var_result expected_results[$];
    t_var_op     sent_op;
    t_var_result want;
    int          send_wait;
    int          recv_wait;
    int          send_gap_max;
    int          recv_gap_max;
    int          results_seen;
    int          mismatch_count;

    function automatic bit local_slot(int s, int v, output int idx);
        idx = frame_ptr[s] - v;
        return (idx >= 0) && (idx < STACK_DEPTH);
    endfunction

    function automatic bit var_get(int s, int v, output zmv_pkg::t_data val);
        int idx;
        val = '0;
        if (v == 0) begin
            if (stack_ptr[s] >= STACK_DEPTH) return 1'b1;
            val = stack_mem[s][stack_ptr[s]];
        end else if (v < zmv_pkg::FIRST_GLOBAL) begin
            if (local_slot(s, v, idx)) val = stack_mem[s][idx];
        end else begin
            val = glob_mem[s][v - zmv_pkg::FIRST_GLOBAL];
        end
        return 1'b0;
    endfunction

    function automatic void var_put(int s, int v, zmv_pkg::t_data val);
        int idx;
        if (v == 0) begin
            if (stack_ptr[s] < STACK_DEPTH) begin
                stack_mem[s][stack_ptr[s]] = val;
                stack_set[s][stack_ptr[s]] = 1'b1;
            end
        end else if (v < zmv_pkg::FIRST_GLOBAL) begin
            if (local_slot(s, v, idx)) begin
                stack_mem[s][idx] = val;
                stack_set[s][idx] = 1'b1;
            end
        end else begin
            glob_mem[s][v - zmv_pkg::FIRST_GLOBAL] = val;
            glob_set[s][v - zmv_pkg::FIRST_GLOBAL] = 1'b1;
        end
    endfunction

    // true when the operation would read a local or global never written
    function automatic bit reads_unset(int s, t_var_op op);
        int  idx;
        bit  reads;
        bit  in_range;
        reads = (op.opcode == zmv_pkg::OP_LOAD) ||
                (op.opcode >= zmv_pkg::OP_INC && op.opcode <= zmv_pkg::OP_DEC_CHK) ||
                (op.opcode == zmv_pkg::OP_FETCH && op.fetch_mode != zmv_pkg::MODE_WORD &&
                 op.fetch_mode != zmv_pkg::MODE_BYTE);
        if (!reads || op.var_number == 0) return 1'b0;
        if (op.var_number < zmv_pkg::FIRST_GLOBAL) begin
            in_range = local_slot(s, op.var_number, idx);
            if (!in_range) return 1'b0;
            return !stack_set[s][idx];
        end
        return !glob_set[s][op.var_number - zmv_pkg::FIRST_GLOBAL];
    endfunction

    function automatic t_var_result apply_var_op(int s, t_var_op op);
        t_var_result    res;
        zmv_pkg::t_data cur;
        bit             err;
        int             v;
        res = '0;
        err = 1'b0;
        v   = op.var_number;
        case (op.opcode)
            zmv_pkg::OP_LOAD: begin
                err = var_get(s, v, cur);
                res.read_value = cur;
            end
            zmv_pkg::OP_STORE: begin
                if (v == 0 && stack_ptr[s] >= STACK_DEPTH) err = 1'b1;
                else var_put(s, v, op.data_value);
            end
            zmv_pkg::OP_PUSH: begin
                if (stack_ptr[s] == 0 || stack_ptr[s] > STACK_DEPTH) begin
                    err = 1'b1;
                end else begin
                    stack_ptr[s] = stack_ptr[s] - 1;
                    stack_mem[s][stack_ptr[s]] = op.data_value;
                    stack_set[s][stack_ptr[s]] = 1'b1;
                end
            end
            zmv_pkg::OP_POP: begin
                if (stack_ptr[s] >= STACK_DEPTH ||
                    (v == 0 && stack_ptr[s] + 1 >= STACK_DEPTH)) begin
                    err = 1'b1;
                end else begin
                    res.read_value = stack_mem[s][stack_ptr[s]];
                    stack_ptr[s] = stack_ptr[s] + 1;
                    var_put(s, v, res.read_value);
                end
            end
            zmv_pkg::OP_INC, zmv_pkg::OP_DEC, zmv_pkg::OP_INC_CHK, zmv_pkg::OP_DEC_CHK: begin
                err = var_get(s, v, cur);
                if (!err) begin
                    if (op.opcode == zmv_pkg::OP_INC || op.opcode == zmv_pkg::OP_INC_CHK)
                        res.read_value = cur + 16'd1;
                    else
                        res.read_value = cur - 16'd1;
                    var_put(s, v, res.read_value);
                    if (op.opcode == zmv_pkg::OP_INC_CHK)
                        res.condition = $signed(res.read_value) > $signed(op.threshold);
                    else if (op.opcode == zmv_pkg::OP_DEC_CHK)
                        res.condition = $signed(res.read_value) < $signed(op.threshold);
                end
            end
            zmv_pkg::OP_FETCH: begin
                if (op.fetch_mode == zmv_pkg::MODE_WORD) begin
                    res.read_value = op.data_value;
                end else if (op.fetch_mode == zmv_pkg::MODE_BYTE) begin
                    res.read_value = {8'h00, op.data_value[7:0]};
                end else if (v == 0) begin
                    if (stack_ptr[s] >= STACK_DEPTH) begin
                        err = 1'b1;
                    end else begin
                        res.read_value = stack_mem[s][stack_ptr[s]];
                        stack_ptr[s] = stack_ptr[s] + 1;
                    end
                end else begin
                    err = var_get(s, v, cur);
                    res.read_value = cur;
                end
            end
            default: ;
        endcase
        if (err) begin
            res = '0;
            res.stack_error = 1'b1;
        end
        return res;
    endfunction

    function automatic zmv_pkg::t_data corner_word();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic t_var_op make_op(zmv_pkg::t_opcode c, zmv_pkg::t_var v,
                                        zmv_pkg::t_data d, zmv_pkg::t_data th,
                                        zmv_pkg::t_mode m);
        t_var_op op;
        op.opcode     = c;
        op.var_number = v;
        op.data_value = d;
        op.threshold  = zmv_pkg::t_threshold'(th);
        op.fetch_mode = m;
        return op;
    endfunction

    function automatic t_var_op random_op(int push_pct);
        t_var_op op;
        int      pick;
        op.data_value = ($urandom_range(0, 3) == 0) ? corner_word()
                                                    : zmv_pkg::t_data'($urandom);
        op.threshold  = ($urandom_range(0, 4) == 0) ? zmv_pkg::t_threshold'(corner_word())
                                                    : zmv_pkg::t_threshold'($urandom);
        op.fetch_mode = zmv_pkg::t_mode'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < push_pct)
            op.opcode = zmv_pkg::OP_PUSH;
        else if (pick < push_pct + 3)
            op.opcode = zmv_pkg::t_opcode'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else
            op.opcode = zmv_pkg::t_opcode'($urandom_range(zmv_pkg::OP_LOAD,
                                                           zmv_pkg::OP_FETCH));
        pick = $urandom_range(0, 99);
        if (pick < 25)
            op.var_number = '0;
        else if (pick < 60)
            op.var_number = zmv_pkg::t_var'($urandom_range(1, zmv_pkg::FIRST_GLOBAL - 1));
        else if (pick < 80)
            op.var_number = zmv_pkg::t_var'($urandom_range(zmv_pkg::FIRST_GLOBAL,
                                                           zmv_pkg::FIRST_GLOBAL + 7));
        else
            op.var_number = zmv_pkg::t_var'($urandom_range(zmv_pkg::FIRST_GLOBAL, 255));
        return op;
    endfunction

    // a read of a never-written variable becomes a store to it
    task automatic queue_op(t_var_op op);
        if (reads_unset(PLAN, op)) op.opcode = zmv_pkg::OP_STORE;
        void'(apply_var_op(PLAN, op));
        pending_ops.push_back(op);
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic write_frame_pointer(int fp);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {zmv_pkg::REG_FP, 2'b00};
        pwdata  <= zmv_pkg::PDATA_W'(fp);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        frame_ptr[LIVE] = fp;
        frame_ptr[PLAN] = fp;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || op_if.valid || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase(int fp, int count, int send_max, int recv_max, int push_pct);
        write_frame_pointer(fp);
        send_gap_max = send_max;
        recv_gap_max = recv_max;
        repeat (count) queue_op(random_op(push_pct));
        wait_drained();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_if.valid <= 1'b0;
        end else if (!op_if.valid || op_if.ready) begin
            if (op_if.valid) expected_results.push_back(apply_var_op(LIVE, sent_op));
            if (send_wait > 0 || pending_ops.size() == 0) begin
                if (send_wait > 0) send_wait--;
                op_if.valid <= 1'b0;
            end else begin
                sent_op = pending_ops.pop_front();
                op_if.opcode     <= sent_op.opcode;
                op_if.var_number <= sent_op.var_number;
                op_if.data_value <= sent_op.data_value;
                op_if.threshold  <= sent_op.threshold;
                op_if.fetch_mode <= sent_op.fetch_mode;
                op_if.valid      <= 1'b1;
                send_wait = $urandom_range(0, send_gap_max);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing expected", results_seen));
                end else begin
                    want = expected_results.pop_front();
                    if (res_if.read_value !== want.read_value)
                        report_mismatch($sformatf("result %0d read_value %04h, expected %04h",
                            results_seen, res_if.read_value, want.read_value));
                    if (res_if.condition !== want.condition)
                        report_mismatch($sformatf("result %0d condition %b, expected %b",
                            results_seen, res_if.condition, want.condition));
                    if (res_if.stack_error !== want.stack_error)
                        report_mismatch($sformatf("result %0d stack_error %b, expected %b",
                            results_seen, res_if.stack_error, want.stack_error));
                end
                results_seen++;
                recv_wait = $urandom_range(0, recv_gap_max);
                // long back-pressure so the unit fills and stalls its input
                if (results_seen == 300) recv_wait = 400;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #800_000;
        $display("zmachine_variable_unit verification failed");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        op_if.valid      = 1'b0;
        op_if.opcode     = zmv_pkg::OP_LOAD;
        op_if.var_number = '0;
        op_if.data_value = '0;
        op_if.threshold  = '0;
        op_if.fetch_mode = zmv_pkg::MODE_WORD;
        res_if.ready     = 1'b0;
        send_wait        = 0;
        recv_wait        = 0;
        results_seen     = 0;
        mismatch_count   = 0;
        send_gap_max     = 3;
        recv_gap_max     = 3;
        for (int s = 0; s < 2; s++) begin
            stack_ptr[s] = STACK_DEPTH;
            frame_ptr[s] = STACK_DEPTH;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty stack, wrap-around, signed checks, fetch modes, spare opcodes
        queue_op(make_op(zmv_pkg::OP_POP, 0, 16'h0000, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_LOAD, 0, 16'h0000, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_FETCH, 0, 16'h1234, 16'h0000, MODE_VAR));
        queue_op(make_op(zmv_pkg::OP_STORE, 0, 16'h5555, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_INC, 0, 16'h0000, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_PUSH, 0, 16'hFFFF, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_POP, 0, 16'h0000, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_INC, 0, 16'h0000, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_PUSH, 0, 16'h7FFF, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_INC_CHK, 0, 16'h0000, 16'h7FFF, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_DEC_CHK, 0, 16'h0000, 16'h8000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_DEC_CHK, 0, 16'h0000, 16'h7FFF, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_INC_CHK, 0, 16'h0000, 16'h7FFF, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_POP, 0, 16'h0000, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_STORE, 255, 16'h8000, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_DEC, 255, 16'h0000, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_INC_CHK, 255, 16'h0000, 16'hFFFF, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_STORE, 1, 16'h00FF, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_FETCH, 1, 16'hABCD, 16'h0000, zmv_pkg::MODE_BYTE));
        queue_op(make_op(zmv_pkg::OP_FETCH, 1, 16'hFFFF, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_FETCH, 1, 16'h0000, 16'h0000, MODE_VAR_ALT));
        queue_op(make_op(zmv_pkg::OP_STORE, GLOBAL_LO, 16'h0000, 16'h0000,
                         zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_DEC_CHK, GLOBAL_LO, 16'h0000, 16'h0000,
                         zmv_pkg::MODE_WORD));
        queue_op(make_op(zmv_pkg::OP_FETCH, 0, 16'h0000, 16'h0000, MODE_VAR));
        queue_op(make_op(zmv_pkg::OP_POP, 255, 16'h0000, 16'h0000, zmv_pkg::MODE_WORD));
        queue_op(make_op(OP_SPARE_HI, 255, 16'hFFFF, 16'hFFFF, MODE_VAR_ALT));
        wait_drained();

        run_phase(STACK_DEPTH, 120, 19, 19, 15);
        run_phase(0, 120, 0, 0, 15);
        run_phase(8, 120, 19, 0, 15);
        run_phase($urandom_range(16, STACK_DEPTH - 1), 120, 0, 19, 15);

        // fill the stack to overflow with other traffic mixed in
        write_frame_pointer(STACK_DEPTH);
        send_gap_max = 6;
        recv_gap_max = 6;
        while (stack_ptr[PLAN] > 0) queue_op(random_op(92));
        repeat (4) queue_op(make_op(zmv_pkg::OP_PUSH, 0, zmv_pkg::t_data'($urandom),
                                    16'h0000, zmv_pkg::MODE_WORD));
        wait_drained();

        run_phase(1, 120, 19, 19, 10);
        run_phase($urandom_range(0, STACK_DEPTH), 100, 10, 10, 10);

        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("zmachine_variable_unit verification clean");
        end else begin
            $display("zmachine_variable_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== zmachine_variable_unit.f =====
design/zmv_pkg.sv
design/zmv_in_if.sv
design/zmv_out_if.sv
design/zmachine_variable_unit.sv
sim/zmachine_variable_unit_tb.sv
